// ===== rtl/core/qbs_pkg.sv =====
// Quadratic Bezier sampler: shared types, constants and the sequencer's control store.
// Depends on nothing; the sampler unit imports it.
package qbs_pkg;

  localparam int COORD_W   = 32;  // signed Q16.16 coordinate
  localparam int CFG_W     = 7;   // sample_count register
  localparam int PIDX_W    = 6;   // point_index field
  localparam int FRAC_BITS = 16;
  localparam int T_W       = 17;  // curve parameter, 0 .. 65536
  localparam int PROD_W    = 52;  // lane product register
  localparam int ACC_W     = 64;  // lane accumulator, sums kept modulo 2^64
  localparam int MUL_A_W   = 17;
  localparam int MUL_B_W   = 35;

  localparam logic [CFG_W-1:0]   SAMPLE_COUNT_RST = 7'd16;
  localparam logic [T_W-1:0]     T_ONE            = 17'h1_0000;
  localparam logic [31:0]        ROUND_HALF       = 32'h8000_0000;

  // bit-serial division of T_ONE by the interval count
  localparam int DIV_STEPS = T_W;
  localparam int DIV_CNT_W = 5;

  // straightness test
  localparam int                 SPAN_SHIFT     = 38;
  localparam logic [63:0]        ONE_METRE_SQ   = 64'd1 << (2 * FRAC_BITS);
  localparam logic [33:0]        SPAN_FLOOR_MIN = 34'(ONE_METRE_SQ >> SPAN_SHIFT);
  localparam logic signed [33:0] BOW_LIMIT      = 34'sd65535;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] control_x;
    logic signed [COORD_W-1:0] control_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [PIDX_W-1:0]         point_index;
    logic                      last_point;
  } out_item_t;

  typedef enum logic [2:0] {
    MUL_SQ_LO,
    MUL_SQ_HI,
    MUL_DSQ,
    MUL_TF,
    MUL_GLO,
    MUL_GHI
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_P,
    ACC_ADD_P16,
    ACC_LOAD_A,
    ACC_ADD_P,
    ACC_ADD_P26
  } acc_op_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_DIV_LEFT,
    COND_MORE_POINTS
  } cond_e;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_WAIT    = 4'd0;
  localparam pc_t PC_SQ_LO   = 4'd1;
  localparam pc_t PC_SQ_HI   = 4'd2;
  localparam pc_t PC_DSQ     = 4'd3;
  localparam pc_t PC_THR     = 4'd4;
  localparam pc_t PC_DIV     = 4'd5;
  localparam pc_t PC_PT_INIT = 4'd6;
  localparam pc_t PC_MUL_F   = 4'd7;
  localparam pc_t PC_ADD_G   = 4'd8;
  localparam pc_t PC_MUL_GLO = 4'd9;
  localparam pc_t PC_MUL_GHI = 4'd10;
  localparam pc_t PC_ACC_HI  = 4'd11;
  localparam pc_t PC_EMIT    = 4'd12;
  localparam pc_t PC_DONE    = 4'd13;

  typedef struct packed {
    logic     take;     // input channel open
    mul_sel_e msel;
    logic     p_en;     // load product register
    acc_op_e  acc_op;
    logic     g_en;     // form inner Horner term
    logic     thr_en;   // decide straightness, pick interval count
    logic     div_en;   // one quotient bit
    logic     pt_init;  // reset parameter walk
    logic     emit;     // hand a point to the output register
    cond_e    cond;
    pc_t      target;
  } ucode_word_t;

  function automatic ucode_word_t ucode_rom(input pc_t pc);
    ucode_word_t w;
    w = '0;
    case (pc)
      PC_WAIT: begin
        w.take   = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = PC_WAIT;
      end
      PC_SQ_LO: begin
        w.msel = MUL_SQ_LO;
        w.p_en = 1'b1;
      end
      PC_SQ_HI: begin
        w.msel   = MUL_SQ_HI;
        w.p_en   = 1'b1;
        w.acc_op = ACC_LOAD_P;
      end
      PC_DSQ: begin
        w.msel   = MUL_DSQ;
        w.p_en   = 1'b1;
        w.acc_op = ACC_ADD_P16;
      end
      PC_THR: begin
        w.thr_en = 1'b1;
      end
      PC_DIV: begin
        w.div_en = 1'b1;
        w.cond   = COND_DIV_LEFT;
        w.target = PC_DIV;
      end
      PC_PT_INIT: begin
        w.pt_init = 1'b1;
      end
      PC_MUL_F: begin
        w.msel = MUL_TF;
        w.p_en = 1'b1;
      end
      PC_ADD_G: begin
        w.g_en   = 1'b1;
        w.acc_op = ACC_LOAD_A;
      end
      PC_MUL_GLO: begin
        w.msel = MUL_GLO;
        w.p_en = 1'b1;
      end
      PC_MUL_GHI: begin
        w.msel   = MUL_GHI;
        w.p_en   = 1'b1;
        w.acc_op = ACC_ADD_P;
      end
      PC_ACC_HI: begin
        w.acc_op = ACC_ADD_P26;
      end
      PC_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_MORE_POINTS;
        w.target = PC_MUL_F;
      end
      PC_DONE: begin
        w.cond   = COND_ALWAYS;
        w.target = PC_WAIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = PC_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/quadratic_bezier_sampler_unit.sv =====
// Quadratic Bezier sampler top level: microcoded sequencer over two coordinate lanes.
// Depends on qbs_pkg for the beat types, constants and the control store.
//
//   channel  dir  handshake            beat
//   cfg      in   cfg_we_i             cfg_data_i (sample_count)
//   in       in   in_valid_i/in_stall_o in_item_t, one curve
//   out      out  out_valid_o/out_stall_i out_item_t, one point
//
// A curve runs through the straightness test, the bit-serial division of 65536 by
// the interval count N-1, the start of the parameter walk, the steps of each of the N
// points through the one 17x35 multiplier of each lane, and a closing step.
// Reset clears the sequencer and the output valid flag and sets sample_count to 16.
// A stalled output holds the sequencer at the emit step; one finished point may wait
// in the output register while the next is computed.
module quadratic_bezier_sampler_unit
  import qbs_pkg::*;
#(
  parameter int MAX_SAMPLES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_data_o
);

  localparam int DW = (MAX_SAMPLES > 2) ? $clog2(MAX_SAMPLES) : 1;

  // sequencer
  pc_t         pc_q, pc_d;
  ucode_word_t cw;
  logic        jump, hold, accept;

  logic [CFG_W-1:0] sample_count_q;
  logic             out_valid_q;
  out_item_t        out_q;

  // lanes: index 0 is x, 1 is y
  logic signed [COORD_W-1:0] in_a [2];
  logic signed [COORD_W-1:0] in_c [2];
  logic signed [COORD_W-1:0] in_b [2];
  logic signed [COORD_W:0]   e_in [2];
  logic signed [COORD_W:0]   diff_in [2];
  logic signed [COORD_W+1:0] f_in [2];
  logic [COORD_W-1:0]        mag_in [2];

  logic signed [COORD_W-1:0] a_q [2];
  logic signed [COORD_W:0]   e_q [2];
  logic signed [COORD_W+1:0] f_q [2];
  logic [COORD_W-1:0]        mag_q [2];
  logic [ACC_W-1:0]          acc_q [2];
  logic [ACC_W-1:0]          acc_d [2];
  logic signed [PROD_W-1:0]  p_q [2];
  logic signed [PROD_W-1:0]  g_q [2];
  logic [COORD_W+1:0]        fabs [2];
  logic                      bent [2];

  logic [MUL_A_W-1:0]                mul_a [2];
  logic signed [MUL_B_W-1:0]         mul_b [2];
  logic signed [MUL_A_W+MUL_B_W:0]   prod [2];

  // straightness decision
  logic [ACC_W:0] span_sum;
  logic [33:0]    span_floor, thr, d2;
  logic           straight;
  logic [DW-1:0]  den_sel;

  // division and parameter walk
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [T_W-1:0]       quo_q;
  logic [DW-1:0]        rem_q;
  logic [DW-1:0]        den_q;
  logic [DW:0]          div_trial;
  logic                 div_fit;
  logic [T_W-1:0]       t_q;
  logic [DW-1:0]        r_q;
  logic [DW-1:0]        k_q;
  logic [DW:0]          r_sum;
  logic                 r_wrap;

  assign cw          = ucode_rom(pc_q);
  assign in_stall_o  = !cw.take;
  assign accept      = in_valid_i && cw.take;
  assign hold        = cw.emit && out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    case (cw.cond)
      COND_NEXT:        jump = 1'b0;
      COND_ALWAYS:      jump = 1'b1;
      COND_NO_INPUT:    jump = !in_valid_i;
      COND_DIV_LEFT:    jump = (div_cnt_q != '0);
      COND_MORE_POINTS: jump = (k_q != den_q);
      default:          jump = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_d = pc_q;
    end else if (jump) begin
      pc_d = cw.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  // curve set-up terms: E = C - A, F = A - 2C + B, |B - A|
  always_comb begin
    in_a[0] = in_data_i.start_x;
    in_a[1] = in_data_i.start_y;
    in_c[0] = in_data_i.control_x;
    in_c[1] = in_data_i.control_y;
    in_b[0] = in_data_i.end_x;
    in_b[1] = in_data_i.end_y;
    for (int i = 0; i < 2; i++) begin
      e_in[i]    = 33'(in_c[i]) - 33'(in_a[i]);
      diff_in[i] = 33'(in_b[i]) - 33'(in_a[i]);
      f_in[i]    = 34'(in_a[i]) - (34'(in_c[i]) <<< 1) + 34'(in_b[i]);
      mag_in[i]  = diff_in[i] < 0 ? 32'(-diff_in[i]) : 32'(diff_in[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      fabs[i] = f_q[i] < 0 ? 34'(-f_q[i]) : 34'(f_q[i]);
      bent[i] = (f_q[i] > BOW_LIMIT) || (f_q[i] < -BOW_LIMIT);
      case (cw.msel)
        MUL_SQ_LO: begin
          mul_a[i] = {1'b0, mag_q[i][15:0]};
          mul_b[i] = 35'(mag_q[i]);
        end
        MUL_SQ_HI: begin
          mul_a[i] = {1'b0, mag_q[i][31:16]};
          mul_b[i] = 35'(mag_q[i]);
        end
        MUL_DSQ: begin
          mul_a[i] = fabs[i][16:0];
          mul_b[i] = 35'(fabs[i][16:0]);
        end
        MUL_TF: begin
          mul_a[i] = t_q;
          mul_b[i] = 35'(f_q[i]);
        end
        MUL_GLO: begin
          mul_a[i] = t_q;
          mul_b[i] = 35'(g_q[i][25:0]);
        end
        MUL_GHI: begin
          mul_a[i] = t_q;
          mul_b[i] = 35'(signed'(g_q[i][51:26]));
        end
        default: begin
          mul_a[i] = t_q;
          mul_b[i] = 35'(f_q[i]);
        end
      endcase
      prod[i] = 53'(signed'({1'b0, mul_a[i]})) * 53'(mul_b[i]);
    end
  end

  // accumulate modulo 2^64: only bits 63:32 of the rounded sum are kept
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      case (cw.acc_op)
        ACC_HOLD:    acc_d[i] = acc_q[i];
        ACC_LOAD_P:  acc_d[i] = 64'(p_q[i]);
        ACC_ADD_P16: acc_d[i] = acc_q[i] + (64'(p_q[i]) << 16);
        ACC_LOAD_A:  acc_d[i] = {a_q[i], ROUND_HALF};
        ACC_ADD_P:   acc_d[i] = acc_q[i] + 64'(p_q[i]);
        ACC_ADD_P26: acc_d[i] = acc_q[i] + (64'(p_q[i]) << 26);
        default:     acc_d[i] = acc_q[i];
      endcase
    end
  end

  // straight when the bow is small against the span squared over 2^38
  always_comb begin
    span_sum   = {1'b0, acc_q[0]} + {1'b0, acc_q[1]};
    span_floor = 34'(span_sum >> SPAN_SHIFT);
    thr        = (span_floor > SPAN_FLOOR_MIN) ? span_floor : SPAN_FLOOR_MIN;
    d2         = 34'(p_q[0][32:0]) + 34'(p_q[1][32:0]);
    straight   = !bent[0] && !bent[1] && (d2 <= thr);
    if (straight || (sample_count_q < 7'd2)) begin
      den_sel = DW'(1);
    end else if (32'(sample_count_q) > 32'(MAX_SAMPLES)) begin
      den_sel = DW'(MAX_SAMPLES - 1);
    end else begin
      den_sel = DW'(sample_count_q - 7'd1);
    end
  end

  always_comb begin
    div_trial = {rem_q, T_ONE[div_cnt_q]};
    div_fit   = (div_trial >= {1'b0, den_q});
    r_sum     = {1'b0, r_q} + {1'b0, rem_q};
    r_wrap    = (r_sum >= {1'b0, den_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q           <= PC_WAIT;
      out_valid_q    <= 1'b0;
      sample_count_q <= SAMPLE_COUNT_RST;
    end else begin
      pc_q <= pc_d;
      if (cfg_we_i) begin
        sample_count_q <= cfg_data_i;
      end
      if (cw.emit && !hold) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 2; i++) begin
      if (accept) begin
        a_q[i]   <= in_a[i];
        e_q[i]   <= e_in[i];
        f_q[i]   <= f_in[i];
        mag_q[i] <= mag_in[i];
      end
      if (cw.p_en) begin
        p_q[i] <= prod[i][PROD_W-1:0];
      end
      if (cw.g_en) begin
        g_q[i] <= (52'(e_q[i]) <<< 17) + p_q[i];
      end
      acc_q[i] <= acc_d[i];
    end

    if (cw.thr_en) begin
      den_q     <= den_sel;
      rem_q     <= '0;
      quo_q     <= '0;
      div_cnt_q <= DIV_CNT_W'(DIV_STEPS - 1);
    end

    // restoring division, one quotient bit a step
    if (cw.div_en) begin
      rem_q     <= div_fit ? DW'(div_trial - {1'b0, den_q}) : DW'(div_trial);
      quo_q     <= {quo_q[T_W-2:0], div_fit};
      div_cnt_q <= div_cnt_q - 1'b1;
    end

    if (cw.pt_init) begin
      t_q <= '0;
      r_q <= den_q >> 1;
      k_q <= '0;
    end

    // advance t by 65536/den with the remainder carried along
    if (cw.emit && !hold) begin
      out_q.point_x     <= acc_q[0][63:32];
      out_q.point_y     <= acc_q[1][63:32];
      out_q.point_index <= PIDX_W'(k_q);
      out_q.last_point  <= (k_q == den_q);
      t_q               <= t_q + quo_q + T_W'(r_wrap);
      r_q               <= r_wrap ? DW'(r_sum - {1'b0, den_q}) : DW'(r_sum);
      k_q               <= k_q + 1'b1;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for quadratic_bezier_sampler_unit: random and directed curves with a
// cycle-free predictor of the sampled points. Depends on qbs_pkg and the sampler RTL only.
module tb_top;
  import qbs_pkg::*;

  localparam int          PT_CAP        = 64;
  localparam int          HOLD_LEN      = 400;
  localparam int          SETTLE        = 8;
  localparam int          REPORT_CAP    = 60;
  localparam logic [63:0] LOW38         = (64'd1 << 38) - 64'd1;
  localparam logic [63:0] UNIT_SQ_FLOOR = (64'd1 << (2 * FRAC_BITS)) >> 38;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [CFG_W-1:0] cfg_data_i  = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_item_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_data_o;

  logic [CFG_W-1:0] sample_cnt = SAMPLE_COUNT_RST;
  out_item_t        pending_points[$];
  int               fail_cnt    = 0;
  bit               quiet       = 1'b0;
  int               hold_ticket = 0;
  int               hold_seen   = 0;
  int               hold_left   = 0;
  int               rx_run      = 0;

  quadratic_bezier_sampler_unit #(
    .MAX_SAMPLES(PT_CAP)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic is_flat(in_item_t c);
    longint      ax, ay, cx, cy, bx, by, dx, dy, ex, ey;
    logic [63:0] mx, my, sa, sb, span_fl, thr, bow;
    ax = longint'(c.start_x);
    ay = longint'(c.start_y);
    cx = longint'(c.control_x);
    cy = longint'(c.control_y);
    bx = longint'(c.end_x);
    by = longint'(c.end_y);
    // twice the offset of the control point from the chord midpoint
    dx = 2 * cx - ax - bx;
    dy = 2 * cy - ay - by;
    if (dx >= 65536 || dx <= -65536 || dy >= 65536 || dy <= -65536) return 1'b0;
    ex = bx - ax;
    ey = by - ay;
    mx = (ex < 0) ? -ex : ex;
    my = (ey < 0) ? -ey : ey;
    sa = mx * mx;
    sb = my * my;
    span_fl = (sa >> 38) + (sb >> 38) + (((sa & LOW38) + (sb & LOW38)) >> 38);
    thr = (span_fl > UNIT_SQ_FLOOR) ? span_fl : UNIT_SQ_FLOOR;
    bow = dx * dx + dy * dy;
    return bow <= thr;
  endfunction

  function automatic logic [31:0] blend_coord(logic signed [31:0] a, logic signed [31:0] c,
                                              logic signed [31:0] b, logic [16:0] t);
    logic signed [95:0] wa, wc, wb, acc;
    logic [63:0]        u;
    u   = 64'd65536 - 64'(t);
    wa  = u * u;
    wc  = 64'd2 * u * 64'(t);
    wb  = 64'(t) * 64'(t);
    acc = wa * a + wc * c + wb * b;
    acc = (acc + (96'sd1 <<< 31)) >>> 32;
    return acc[31:0];
  endfunction

  task automatic predict_points(in_item_t c);
    out_item_t   p;
    int          n, k;
    int unsigned den, t;
    if (is_flat(c)) begin
      p.point_x     = c.start_x;
      p.point_y     = c.start_y;
      p.point_index = '0;
      p.last_point  = 1'b0;
      pending_points.push_back(p);
      p.point_x     = c.end_x;
      p.point_y     = c.end_y;
      p.point_index = PIDX_W'(1);
      p.last_point  = 1'b1;
      pending_points.push_back(p);
      return;
    end
    n = (sample_cnt < 2) ? 2 : int'(sample_cnt);
    if (n > PT_CAP) n = PT_CAP;
    den = n - 1;
    for (k = 0; k < n; k++) begin
      t = (k * 65536 + den / 2) / den;
      p.point_x     = blend_coord(c.start_x, c.control_x, c.end_x, t[16:0]);
      p.point_y     = blend_coord(c.start_y, c.control_y, c.end_y, t[16:0]);
      p.point_index = PIDX_W'(k);
      p.last_point  = (k == n - 1);
      pending_points.push_back(p);
    end
  endtask

  // ---------------------------------------------------------------- checker

  task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      fail_cnt++;
      // keep the log bounded on a badly broken build
      if (fail_cnt <= REPORT_CAP) $error("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_data_o;
      if (pending_points.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_CAP)
          $error("point beat with nothing expected: x=%0d y=%0d index=%0d",
                 got.point_x, got.point_y, got.point_index);
      end else begin
        want = pending_points.pop_front();
        check_field("point_x", want.point_x, got.point_x);
        check_field("point_y", want.point_y, got.point_y);
        check_field("point_index", {58'd0, want.point_index}, {58'd0, got.point_index});
        check_field("last_point", {63'd0, want.last_point}, {63'd0, got.last_point});
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(20, 90);
  endfunction

  always @(posedge clk_i) begin
    if (hold_ticket != hold_seen) begin
      hold_seen = hold_ticket;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else if (rx_run > 0) begin
      rx_run--;
    end else if (!out_stall_i && $urandom_range(0, 99) < 45) begin
      out_stall_i <= 1'b1;
      rx_run = stall_len() - 1;
    end else begin
      out_stall_i <= 1'b0;
      rx_run = $urandom_range(0, 7);
    end
  end

  // ---------------------------------------------------------------- sender

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(25, 80);
  endfunction

  // Valid stays high across back-to-back beats; drop it only ahead of a gap.
  task automatic send_curve(in_item_t c);
    int gap;
    gap = quiet ? 0 : sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_data_i  <= c;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_points(c);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_count(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_data_i <= v;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sample_cnt = v;
  endtask

  // ---------------------------------------------------------------- curve makers

  function automatic in_item_t make_curve(logic [31:0] ax, logic [31:0] ay, logic [31:0] cx,
                                          logic [31:0] cy, logic [31:0] bx, logic [31:0] by);
    in_item_t c;
    c.start_x   = ax;
    c.start_y   = ay;
    c.control_x = cx;
    c.control_y = cy;
    c.end_x     = bx;
    c.end_y     = by;
    return c;
  endfunction

  function automatic in_item_t rand_curve();
    return make_curve($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  function automatic longint place_control(longint mid, int spread);
    longint v;
    v = mid + longint'($urandom_range(0, 2 * spread)) - longint'(spread);
    if (v > 64'sd2147483647 || v < -64'sd2147483648) v = mid;
    return v;
  endfunction

  // Control point near the chord midpoint: straight or just past the tolerance.
  function automatic in_item_t flat_curve(int spread);
    in_item_t c;
    int       sh;
    longint   mx, my;
    c  = rand_curve();
    sh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : 0;
    c.start_x = c.start_x >>> sh;
    c.start_y = c.start_y >>> sh;
    c.end_x   = c.end_x >>> sh;
    c.end_y   = c.end_y >>> sh;
    mx = (longint'(c.start_x) + longint'(c.end_x)) >>> 1;
    my = (longint'(c.start_y) + longint'(c.end_y)) >>> 1;
    c.control_x = 32'(place_control(mx, spread));
    c.control_y = 32'(place_control(my, spread));
    return c;
  endfunction

  function automatic in_item_t mixed_curve();
    int r, spread;
    r = $urandom_range(0, 99);
    if (r < 45) return rand_curve();
    if (r < 85) begin
      case ($urandom_range(0, 4))
        0:       spread = 0;
        1:       spread = 2;
        2:       spread = 300;
        3:       spread = 3000;
        default: spread = 20000;
      endcase
      return flat_curve(spread);
    end
    return make_curve(corner_value(), corner_value(), corner_value(),
                      corner_value(), corner_value(), corner_value());
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_straight_curves();
    quiet = 1'b0;
    // degenerate curve, all points at the origin
    send_curve(make_curve(0, 0, 0, 0, 0, 0));
    // control exactly on the midpoint
    send_curve(make_curve(32'h0001_0000, 32'hFFFE_0000, 32'h0005_8000, 32'h0001_0000,
                          32'h000A_0000, 32'h0004_0000));
    // full-range chord, control within half a bit of the midpoint
    send_curve(make_curve(32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_curve(make_curve(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
    // zero span: the tolerance is nil, so any bow samples the full run
    send_curve(make_curve(0, 0, 1, 0, 0, 0));
    // right on the tolerance, then one step past it
    send_curve(make_curve(0, 0, 32'h2000_0400, 0, 32'h4000_0000, 0));
    send_curve(make_curve(0, 0, 32'h2000_0401, 0, 32'h4000_0000, 0));
  endtask

  task automatic test_extreme_fields();
    send_curve(make_curve(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF));
    send_curve(make_curve(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h8000_0000, 32'h7FFF_FFFF));
    send_curve(make_curve(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'hFFFF_FFFF));
    send_curve(make_curve(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h8000_0000));
  endtask

  task automatic test_sample_counts();
    logic [CFG_W-1:0] counts[8];
    int               i;
    counts = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd63, 7'd64, 7'd65, 7'd127};
    for (i = 0; i < 8; i++) begin
      set_count(counts[i]);
      send_curve(rand_curve());
    end
    // straight curve ignores the count
    send_curve(flat_curve(0));
  endtask

  task automatic test_backpressure();
    int i;
    set_count(7'd6);
    quiet = 1'b1;
    hold_ticket++;
    // keep offering beats while the receiver holds off; the block must back up
    for (i = 0; i < 12; i++) send_curve(mixed_curve());
    quiet = 1'b0;
  endtask

  task automatic test_random_phases();
    logic [CFG_W-1:0] counts[15];
    int               ph, i, n;
    counts = '{7'd2, 7'd0, 7'd5, 7'd3, 7'd9, 7'd1, 7'd64, 7'd4, 7'd127, 7'd12, 7'd65,
               7'd7, 7'd0, 7'd0, 7'd0};
    // last two phases draw their count at random
    counts[13] = 7'($urandom_range(0, 127));
    counts[14] = 7'($urandom_range(0, 127));
    for (ph = 0; ph < 15; ph++) begin
      set_count(counts[ph]);
      quiet = (ph % 4 == 2);
      n = (counts[ph] >= 32) ? 9 : 22;
      for (i = 0; i < n; i++) send_curve(mixed_curve());
    end
    quiet = 1'b0;
  endtask

  task automatic test_pause_and_resume();
    int i;
    set_count(7'd3);
    for (i = 0; i < 6; i++) send_curve(mixed_curve());
    // hold the sender until every point is back
    wait_idle();
    for (i = 0; i < 6; i++) send_curve(mixed_curve());
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_straight_curves();
    test_extreme_fields();
    test_sample_counts();
    test_backpressure();
    test_random_phases();
    test_pause_and_resume();
    wait_idle();
    repeat (32) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/qbs_pkg.sv
rtl/core/quadratic_bezier_sampler_unit.sv
tb/tb_top.sv
